/* rtl/crs_pkg.sv */
// ----------------------------------------------------------------------------
// crs_pkg
// Shared constants and helpers for the command retry scheduler.
// ----------------------------------------------------------------------------
package crs_pkg;

   localparam int SLOTS_DEF = 4;

   // input modes
   localparam logic [1:0] MODE_CMD   = 2'd0;
   localparam logic [1:0] MODE_DATA  = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;
   localparam logic [1:0] MODE_REPLY = 2'd3;

   // result events
   localparam logic [2:0] EV_ACCEPT   = 3'd0;
   localparam logic [2:0] EV_REJECT   = 3'd1;
   localparam logic [2:0] EV_SEND_CMD = 3'd2;
   localparam logic [2:0] EV_SEND_DAT = 3'd3;
   localparam logic [2:0] EV_FINISH   = 3'd4;

   // finish outcomes
   localparam logic [1:0] OUT_OK    = 2'd0;
   localparam logic [1:0] OUT_ERROR = 2'd1;
   localparam logic [1:0] OUT_OVER  = 2'd2;

   // reply codes
   localparam logic [2:0] RC_OK        = 3'd0;
   localparam logic [2:0] RC_ERROR     = 3'd1;
   localparam logic [2:0] RC_FAIL      = 3'd2;
   localparam logic [2:0] RC_BUSY      = 3'd3;
   localparam logic [2:0] RC_PROMPT    = 3'd4;
   localparam logic [2:0] RC_SEND_OK   = 3'd5;
   localparam logic [2:0] RC_SEND_FAIL = 3'd6;
   localparam logic [2:0] RC_NONE      = 3'd7;

   // config register indexes
   localparam logic CSR_DATA_ATTEMPTS = 1'b0;
   localparam logic CSR_DATA_TIMEOUT  = 1'b1;

   localparam logic [7:0]  DATA_ATTEMPTS_RST = 8'd3;
   localparam logic [12:0] DATA_TIMEOUT_RST  = 13'd500;

   // fixed part of the data send command line
   localparam logic [16:0] SEND_CMD_BASE = 17'd14;

   // x / 10 as (x * 52429) >> 19, exact for 16-bit x
   localparam logic [15:0] DIV10_MUL = 16'd52429;

   function automatic logic [2:0] digits16(input logic [15:0] v);
      logic [2:0] d;
      if (v >= 16'd10000) d = 3'd5;
      else if (v >= 16'd1000) d = 3'd4;
      else if (v >= 16'd100) d = 3'd3;
      else if (v >= 16'd10) d = 3'd2;
      else d = 3'd1;
      return d;
   endfunction

   function automatic logic [16:0] cmd_len(input logic is_data, input logic [7:0] link,
                                           input logic [15:0] len);
      logic [16:0] r;
      if (is_data)
         r = SEND_CMD_BASE + {14'd0, digits16({8'd0, link})} + {14'd0, digits16(len)};
      else
         r = {1'b0, len};
      return r;
   endfunction

endpackage

/* rtl/command_retry_scheduler.sv */
// ----------------------------------------------------------------------------
// command_retry_scheduler
// Slot pool with free, ready and wait queues for half-duplex command traffic.
// ----------------------------------------------------------------------------
// Usage: raise start with req_mode and the item fields while busy is low; the
// item is taken at that edge and busy stays high until its last result is
// staged; that result reaches the ports once busy is low. Results appear on the
// rsp_ ports for one cycle each, marked by rsp_strobe; rsp_last flags the
// final result of an item. The receiver cannot stall, so results are never
// held. Config registers are written through csr_we / csr_index / csr_wdata
// while the block is idle; the user must keep to that, as it is not enforced.
// Timing: an enqueue or a reply passes through its own state, then flush. A
// tick sequencer visits one queue position per cycle through a shared
// timer-compare unit, save an extra state after a send that also finishes;
// it scans the wait queue, then the ready queue if no slot is left waiting.
// Results wait in a pending register, as the last flag is only known when
// the next result or the end of the item shows up.
// Reset: ready and wait queues empty, all slots free in order, config
// registers at their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module command_retry_scheduler #(
   parameter int SLOTS = crs_pkg::SLOTS_DEF,
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int CW = $clog2(SLOTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [1:0]    req_mode,
   input  logic [15:0]   req_tag,
   input  logic [15:0]   req_length,
   input  logic [7:0]    req_link,
   input  logic [2:0]    req_expect_code,
   input  logic [2:0]    req_fail_code,
   input  logic [7:0]    req_attempts,
   input  logic [15:0]   req_reply_wait_ms,
   input  logic [2:0]    req_reply_code,
   input  logic [15:0]   req_uart_space,
   output logic          rsp_strobe,
   output logic [2:0]    rsp_event_res,
   output logic [SW-1:0] rsp_slot,
   output logic [15:0]   rsp_tag_out,
   output logic [15:0]   rsp_length_out,
   output logic [7:0]    rsp_link_out,
   output logic [1:0]    rsp_outcome,
   output logic          rsp_last,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [12:0]   csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ENQ   = 3'd1;
   localparam logic [2:0] ST_REPLY = 3'd2;
   localparam logic [2:0] ST_TICK  = 3'd3;
   localparam logic [2:0] ST_WSCAN = 3'd4;
   localparam logic [2:0] ST_RSCAN = 3'd5;
   localparam logic [2:0] ST_RFIN  = 3'd6;
   localparam logic [2:0] ST_FLUSH = 3'd7;

   // config
   logic [7:0]  data_att_ff;
   logic [12:0] data_tmo_ff;

   // sequencer
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [SW-1:0] cur_ff, cur_in;

   // latched item
   logic [1:0]  mode_ff;
   logic [15:0] tag_ff, len_ff, space_ff;
   logic [7:0]  link_ff, att_ff;
   logic [2:0]  exp_ff, fail_ff, reply_ff;
   logic [12:0] tmo_ff;
   logic [31:0] div_prod;
   logic [12:0] div_q;

   // queues
   logic [SW-1:0] rq_ff [SLOTS], rq_in [SLOTS];
   logic [SW-1:0] wq_ff [SLOTS], wq_in [SLOTS];
   logic [SW-1:0] fq_ff [SLOTS], fq_in [SLOTS];
   logic [CW-1:0] rc_ff, rc_in, wc_ff, wc_in, fc_ff, fc_in;

   // slot entries
   logic [15:0] e_tag_ff [SLOTS], e_tag_in [SLOTS];
   logic [15:0] e_len_ff [SLOTS], e_len_in [SLOTS];
   logic [7:0]  e_link_ff [SLOTS], e_link_in [SLOTS];
   logic [2:0]  e_exp_ff [SLOTS], e_exp_in [SLOTS];
   logic [2:0]  e_fail_ff [SLOTS], e_fail_in [SLOTS];
   logic [7:0]  e_att_ff [SLOTS], e_att_in [SLOTS];
   logic [12:0] e_tmo_ff [SLOTS], e_tmo_in [SLOTS];
   logic [12:0] e_tmr_ff [SLOTS], e_tmr_in [SLOTS];
   logic        e_dat_ff [SLOTS], e_dat_in [SLOTS];
   logic        e_stg_ff [SLOTS], e_stg_in [SLOTS];

   // pending result, held until the next one tells whether it was last
   logic          pv_ff, pv_in;
   logic [2:0]    pev_ff, pev_in;
   logic [SW-1:0] pslot_ff, pslot_in;
   logic [15:0]   ptag_ff, ptag_in, plen_ff, plen_in;
   logic [7:0]    plink_ff, plink_in;
   logic [1:0]    pout_ff, pout_in;

   logic          rv_ff, rv_in, rlast_ff, rlast_in;
   logic [2:0]    rev_ff, rev_in;
   logic [SW-1:0] rslot_ff, rslot_in;
   logic [15:0]   rtag_ff, rtag_in, rlen_ff, rlen_in;
   logic [7:0]    rlink_ff, rlink_in;
   logic [1:0]    rout_ff, rout_in;

   // shared unit operands
   logic [SW-1:0] s;
   logic [13:0]   tnext;
   logic          tover;
   logic [16:0]   clen;
   logic          accept;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign div_prod = {16'd0, req_reply_wait_ms} * {16'd0, crs_pkg::DIV10_MUL};
   assign div_q    = div_prod[31:19];

   always_comb begin
      logic          ev_v;
      logic [2:0]    ev_e;
      logic [SW-1:0] ev_s;
      logic [15:0]   ev_t, ev_l;
      logic [7:0]    ev_k;
      logic [1:0]    ev_o;
      logic          rm_w, rm_r, rm_f, push_r, push_w, push_f;
      logic [CW-1:0] rm_pos;

      state_in = state_ff;
      idx_in   = idx_ff;
      cur_in   = cur_ff;
      rq_in = rq_ff; wq_in = wq_ff; fq_in = fq_ff;
      rc_in = rc_ff; wc_in = wc_ff; fc_in = fc_ff;
      e_tag_in = e_tag_ff; e_len_in = e_len_ff; e_link_in = e_link_ff;
      e_exp_in = e_exp_ff; e_fail_in = e_fail_ff; e_att_in = e_att_ff;
      e_tmo_in = e_tmo_ff; e_tmr_in = e_tmr_ff; e_dat_in = e_dat_ff;
      e_stg_in = e_stg_ff;
      ev_v = 1'b0; ev_e = crs_pkg::EV_ACCEPT; ev_s = '0; ev_t = '0; ev_l = '0;
      ev_k = '0; ev_o = crs_pkg::OUT_OK;
      rm_w = 1'b0; rm_r = 1'b0; rm_f = 1'b0;
      push_r = 1'b0; push_w = 1'b0; push_f = 1'b0;
      rm_pos = '0;

      s = cur_ff;
      case (state_ff)
         ST_ENQ:   s = fq_ff[0];
         ST_REPLY: s = wq_ff[0];
         ST_WSCAN: s = wq_ff[idx_ff[SW-1:0]];
         ST_RSCAN: s = rq_ff[idx_ff[SW-1:0]];
         default:  s = cur_ff;
      endcase
      tnext = {1'b0, e_tmr_ff[s]} + 14'd1;
      tover = tnext > {1'b0, e_tmo_ff[s]};
      clen  = crs_pkg::cmd_len(e_dat_ff[s], e_link_ff[s], e_len_ff[s]);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  crs_pkg::MODE_CMD, crs_pkg::MODE_DATA: state_in = ST_ENQ;
                  crs_pkg::MODE_TICK: state_in = ST_TICK;
                  default: state_in = ST_REPLY;
               endcase
            end
         end
         ST_ENQ: begin
            ev_v = 1'b1;
            ev_t = tag_ff;
            state_in = ST_FLUSH;
            if (len_ff == 16'd0 || fc_ff == '0) begin
               ev_e = crs_pkg::EV_REJECT;
            end else begin
               ev_s = s;
               rm_f = 1'b1;
               push_r = 1'b1;
               cur_in = s;
               e_tag_in[s] = tag_ff;
               e_len_in[s] = len_ff;
               e_stg_in[s] = 1'b0;
               if (mode_ff == crs_pkg::MODE_DATA) begin
                  e_link_in[s] = link_ff;
                  e_exp_in[s]  = crs_pkg::RC_PROMPT;
                  e_fail_in[s] = crs_pkg::RC_ERROR;
                  e_att_in[s]  = data_att_ff;
                  e_tmo_in[s]  = data_tmo_ff;
                  e_tmr_in[s]  = data_tmo_ff;
                  e_dat_in[s]  = 1'b1;
               end else begin
                  e_link_in[s] = '0;
                  e_exp_in[s]  = exp_ff;
                  e_fail_in[s] = fail_ff;
                  e_att_in[s]  = att_ff;
                  e_tmo_in[s]  = tmo_ff;
                  e_tmr_in[s]  = tmo_ff;
                  e_dat_in[s]  = 1'b0;
               end
            end
         end
         ST_REPLY: begin
            state_in = ST_FLUSH;
            if (wc_ff != '0) begin
               if (reply_ff == crs_pkg::RC_ERROR || reply_ff == crs_pkg::RC_FAIL ||
                   reply_ff == crs_pkg::RC_BUSY ||
                   (e_fail_ff[s] != crs_pkg::RC_NONE && reply_ff == e_fail_ff[s])) begin
                  rm_w = 1'b1; push_f = 1'b1;
                  ev_v = 1'b1; ev_e = crs_pkg::EV_FINISH; ev_s = s; ev_t = e_tag_ff[s];
                  ev_o = crs_pkg::OUT_ERROR;
               end else if (e_exp_ff[s] != crs_pkg::RC_NONE && reply_ff == e_exp_ff[s]) begin
                  if (e_dat_ff[s] && !e_stg_ff[s]) begin
                     ev_v = 1'b1; ev_e = crs_pkg::EV_SEND_DAT; ev_s = s;
                     ev_t = e_tag_ff[s]; ev_l = e_len_ff[s]; ev_k = e_link_ff[s];
                     e_stg_in[s]  = 1'b1;
                     e_exp_in[s]  = crs_pkg::RC_SEND_OK;
                     e_fail_in[s] = crs_pkg::RC_SEND_FAIL;
                     e_tmr_in[s]  = '0;
                  end else begin
                     rm_w = 1'b1; push_f = 1'b1;
                     ev_v = 1'b1; ev_e = crs_pkg::EV_FINISH; ev_s = s; ev_t = e_tag_ff[s];
                     ev_o = crs_pkg::OUT_OK;
                  end
               end
            end
         end
         ST_TICK: begin
            idx_in = '0;
            state_in = (wc_ff == '0 && rc_ff == '0) ? ST_FLUSH : ST_WSCAN;
         end
         ST_WSCAN: begin
            if (idx_ff < wc_ff) begin
               if (tover) begin
                  e_tmr_in[s] = '0;
                  rm_w = 1'b1; rm_pos = idx_ff;
                  e_att_in[s] = e_att_ff[s] - 8'd1;
                  if (e_att_ff[s] == 8'd1) begin
                     push_f = 1'b1;
                     ev_v = 1'b1; ev_e = crs_pkg::EV_FINISH; ev_s = s; ev_t = e_tag_ff[s];
                     ev_o = crs_pkg::OUT_OVER;
                  end else begin
                     if (e_dat_ff[s] && e_stg_ff[s]) begin
                        e_stg_in[s]  = 1'b0;
                        e_exp_in[s]  = crs_pkg::RC_PROMPT;
                        e_fail_in[s] = crs_pkg::RC_ERROR;
                     end
                     push_r = 1'b1;
                  end
               end else begin
                  e_tmr_in[s] = tnext[12:0];
                  idx_in = idx_ff + CW'(1);
               end
            end else begin
               idx_in = '0;
               state_in = (wc_ff != '0) ? ST_FLUSH : ST_RSCAN;
            end
         end
         ST_RSCAN: begin
            if (idx_ff < rc_ff) begin
               if (tover) begin
                  e_tmr_in[s] = '0;
                  if (clen > {1'b0, space_ff}) begin
                     idx_in = idx_ff + CW'(1);
                  end else begin
                     rm_r = 1'b1; rm_pos = idx_ff;
                     cur_in = s;
                     ev_v = 1'b1; ev_e = crs_pkg::EV_SEND_CMD; ev_s = s;
                     ev_t = e_tag_ff[s]; ev_l = clen[15:0];
                     ev_k = e_dat_ff[s] ? e_link_ff[s] : 8'd0;
                     if (e_att_ff[s] != 8'd0) begin
                        push_w = 1'b1;
                        state_in = ST_FLUSH;
                     end else begin
                        state_in = ST_RFIN;
                     end
                  end
               end else begin
                  e_tmr_in[s] = tnext[12:0];
                  idx_in = idx_ff + CW'(1);
               end
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_RFIN: begin
            push_f = 1'b1;
            ev_v = 1'b1; ev_e = crs_pkg::EV_FINISH; ev_s = cur_ff; ev_t = e_tag_ff[cur_ff];
            ev_o = crs_pkg::OUT_OK;
            state_in = ST_RSCAN;
         end
         ST_FLUSH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase

      // queue removals shift the tail down one place
      for (int k = 0; k < SLOTS - 1; k++) begin
         if (rm_w && CW'(k) >= rm_pos) wq_in[k] = wq_ff[k + 1];
         if (rm_r && CW'(k) >= rm_pos) rq_in[k] = rq_ff[k + 1];
         if (rm_f) fq_in[k] = fq_ff[k + 1];
      end
      if (rm_w) wc_in = wc_ff - CW'(1);
      if (rm_r) rc_in = rc_ff - CW'(1);
      if (rm_f) fc_in = fc_ff - CW'(1);
      if (push_r) begin
         rq_in[rc_ff[SW-1:0]] = s;
         rc_in = rc_ff + CW'(1);
      end
      if (push_w) begin
         wq_in[wc_ff[SW-1:0]] = s;
         wc_in = wc_ff + CW'(1);
      end
      if (push_f) begin
         fq_in[fc_ff[SW-1:0]] = ev_s;
         fc_in = fc_ff + CW'(1);
      end

      // result staging
      pv_in = pv_ff; pev_in = pev_ff; pslot_in = pslot_ff; ptag_in = ptag_ff;
      plen_in = plen_ff; plink_in = plink_ff; pout_in = pout_ff;
      rv_in = 1'b0; rlast_in = 1'b0; rev_in = pev_ff; rslot_in = pslot_ff;
      rtag_in = ptag_ff; rlen_in = plen_ff; rlink_in = plink_ff; rout_in = pout_ff;
      if (ev_v) begin
         rv_in = pv_ff;
         pv_in = 1'b1; pev_in = ev_e; pslot_in = ev_s; ptag_in = ev_t;
         plen_in = ev_l; plink_in = ev_k; pout_in = ev_o;
      end else if (state_ff == ST_FLUSH) begin
         rv_in = pv_ff;
         rlast_in = 1'b1;
         pv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cur_ff   <= '0;
         rc_ff    <= '0;
         wc_ff    <= '0;
         fc_ff    <= CW'(SLOTS);
         for (int k = 0; k < SLOTS; k++) begin
            fq_ff[k] <= SW'(k);
            rq_ff[k] <= '0;
            wq_ff[k] <= '0;
         end
         pv_ff       <= 1'b0;
         rv_ff       <= 1'b0;
         data_att_ff <= crs_pkg::DATA_ATTEMPTS_RST;
         data_tmo_ff <= crs_pkg::DATA_TIMEOUT_RST;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cur_ff   <= cur_in;
         rc_ff    <= rc_in;
         wc_ff    <= wc_in;
         fc_ff    <= fc_in;
         rq_ff    <= rq_in;
         wq_ff    <= wq_in;
         fq_ff    <= fq_in;
         pv_ff    <= pv_in;
         rv_ff    <= rv_in;
         if (csr_we) begin
            case (csr_index)
               crs_pkg::CSR_DATA_ATTEMPTS: data_att_ff <= csr_wdata[7:0];
               crs_pkg::CSR_DATA_TIMEOUT:  data_tmo_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         tag_ff   <= req_tag;
         len_ff   <= req_length;
         link_ff  <= req_link;
         exp_ff   <= req_expect_code;
         fail_ff  <= req_fail_code;
         att_ff   <= req_attempts;
         tmo_ff   <= (div_q == 13'd0) ? 13'd1 : div_q;
         reply_ff <= req_reply_code;
         space_ff <= req_uart_space;
      end
      e_tag_ff  <= e_tag_in;
      e_len_ff  <= e_len_in;
      e_link_ff <= e_link_in;
      e_exp_ff  <= e_exp_in;
      e_fail_ff <= e_fail_in;
      e_att_ff  <= e_att_in;
      e_tmo_ff  <= e_tmo_in;
      e_tmr_ff  <= e_tmr_in;
      e_dat_ff  <= e_dat_in;
      e_stg_ff  <= e_stg_in;
      pev_ff    <= pev_in;
      pslot_ff  <= pslot_in;
      ptag_ff   <= ptag_in;
      plen_ff   <= plen_in;
      plink_ff  <= plink_in;
      pout_ff   <= pout_in;
      rlast_ff  <= rlast_in;
      rev_ff    <= rev_in;
      rslot_ff  <= rslot_in;
      rtag_ff   <= rtag_in;
      rlen_ff   <= rlen_in;
      rlink_ff  <= rlink_in;
      rout_ff   <= rout_in;
   end

   assign rsp_strobe     = rv_ff;
   assign rsp_event_res  = rev_ff;
   assign rsp_slot       = rslot_ff;
   assign rsp_tag_out    = rtag_ff;
   assign rsp_length_out = rlen_ff;
   assign rsp_link_out   = rlink_ff;
   assign rsp_outcome    = rout_ff;
   assign rsp_last       = rlast_ff;

endmodule
